// File: hdl/zoned_steering_position_drive_core_macros.svh
// ----------------------------------------------------------------------------
// Zoned steering position drive - assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ZONED_STEERING_POSITION_DRIVE_CORE_MACROS_SVH
`define ZONED_STEERING_POSITION_DRIVE_CORE_MACROS_SVH

// same-cycle implication or plain property
`define ZSPD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition now, property on the next edge
`define ZSPD_ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: hdl/zsd_pkg.sv
// ----------------------------------------------------------------------------
// zsd_pkg
// Shared types, codes and constants of the zoned steering position drive.
// ----------------------------------------------------------------------------
package zsd_pkg;

	localparam int POS_W   = 24;          // encoder position width
	localparam int FIELD_W = 24;          // position port and band width
	localparam int ANGLE_W = 12;
	localparam int TPD_W   = 10;
	localparam int DUTY_W  = 10;
	localparam int PROD_W  = ANGLE_W + TPD_W;
	localparam int START_W = (POS_W > PROD_W + 1) ? POS_W : PROD_W + 1;
	localparam int DIST_W  = ((POS_W > FIELD_W) ? POS_W : FIELD_W) + 2;

	localparam logic [DUTY_W-1:0] DUTY_WRAP_AT      = DUTY_W'(620);
	localparam logic [DUTY_W-1:0] DUTY_WRAP_TO      = DUTY_W'(100);
	localparam logic [DUTY_W-1:0] DUTY_COARSE_START = DUTY_W'(300);
	localparam logic [DUTY_W-1:0] DUTY_NEXT_START   = DUTY_W'(200);
	localparam logic [DUTY_W-1:0] COMPARE_OFFSET    = DUTY_W'(2);
	localparam logic [DUTY_W-1:0] COMPARE_MAX       = DUTY_W'(617);

	localparam logic [TPD_W-1:0]   TPD_RESET    = TPD_W'(203);
	localparam logic [FIELD_W-1:0] COARSE_RESET = FIELD_W'(3500);
	localparam logic [FIELD_W-1:0] MEDIUM_RESET = FIELD_W'(2000);
	localparam logic [FIELD_W-1:0] STOP_RESET   = FIELD_W'(200);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_COARSE = 2'd1,
		PH_MEDIUM = 2'd2,
		PH_FINE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BACK = 2'd2
	} dir_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_TPD    = 2'd0,
		CFG_COARSE = 2'd1,
		CFG_MEDIUM = 2'd2,
		CFG_STOP   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TPD_W-1:0]   tpd;
		logic [FIELD_W-1:0] coarse_band;
		logic [FIELD_W-1:0] medium_band;
		logic [FIELD_W-1:0] stop_band;
	} cfg_t;

	typedef struct packed {
		dir_t              dir;
		logic [DUTY_W-1:0] cmp;
		logic              busy;
		logic              done;
	} res_t;

endpackage

// File: hdl/zsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// zsd_cfg_regs
// Configuration register file, one write per transfer, always ready.
// ----------------------------------------------------------------------------
module zsd_cfg_regs
	import zsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [FIELD_W-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tpd         <= TPD_RESET;
			cfg_q.coarse_band <= COARSE_RESET;
			cfg_q.medium_band <= MEDIUM_RESET;
			cfg_q.stop_band   <= STOP_RESET;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_TPD:    cfg_q.tpd         <= wr_data[TPD_W-1:0];
				CFG_COARSE: cfg_q.coarse_band <= wr_data;
				CFG_MEDIUM: cfg_q.medium_band <= wr_data;
				CFG_STOP:   cfg_q.stop_band   <= wr_data;
				default:    ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/zsd_drive.sv
// ----------------------------------------------------------------------------
// zsd_drive
// Move state and the single-pass step: start decision and phase sequencing.
// ----------------------------------------------------------------------------
module zsd_drive
	import zsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  op_t                opcode,
	input  logic [ANGLE_W-1:0] target_angle,
	input  logic [FIELD_W-1:0] position,
	input  cfg_t               cfg,
	output res_t               res
);

	function automatic logic [DUTY_W-1:0] duty_bump(input logic [DUTY_W-1:0] d);
		logic [DUTY_W:0] n;
		n = {1'b0, d} + (DUTY_W+1)'(1);
		if (n >= {1'b0, DUTY_WRAP_AT})
			return DUTY_WRAP_TO;
		return n[DUTY_W-1:0];
	endfunction

	phase_t            phase_q, phase_d;
	dir_t              dir_q, dir_d;
	logic [DUTY_W-1:0] duty_q, duty_d;
	logic [POS_W-1:0]  tt_q, tt_d;

	logic [TPD_W-1:0]   tpd_eff;
	logic [PROD_W-1:0]  prod;
	logic [START_W-1:0] pos_st, lo_st, hi_st;
	logic               below, above;
	logic [POS_W-1:0]   pos_m;
	logic [DIST_W-1:0]  pos_x, tt_x, dist_u;
	logic signed [DIST_W-1:0] distance;
	logic               gt_c, gt_m, gt_s;
	logic               run_c, at_med, run_m, at_fine, run_f;
	logic [DUTY_W-1:0]  med_duty, fine_duty, bump_c, bump_m, bump_f;

	// start: floor(pos/tpd) vs angle, done as pos vs angle*tpd and angle*tpd+tpd
	assign tpd_eff = (cfg.tpd == '0) ? TPD_W'(1) : cfg.tpd;
	assign prod    = PROD_W'(target_angle) * PROD_W'(tpd_eff);
	assign pos_m   = POS_W'(position);
	assign pos_st  = START_W'(pos_m);
	assign lo_st   = START_W'(prod);
	assign hi_st   = START_W'(prod) + START_W'(tpd_eff);
	assign below   = pos_st < lo_st;
	assign above   = pos_st >= hi_st;

	// signed distance in the direction of travel
	assign pos_x    = DIST_W'(pos_m);
	assign tt_x     = DIST_W'(tt_q);
	assign dist_u   = (dir_q == DIR_BACK) ? (tt_x - pos_x) : (pos_x - tt_x);
	assign distance = signed'(dist_u);
	assign gt_c     = distance > signed'(DIST_W'(cfg.coarse_band));
	assign gt_m     = distance > signed'(DIST_W'(cfg.medium_band));
	assign gt_s     = distance > signed'(DIST_W'(cfg.stop_band));

	// phases fall through on the same sample
	assign run_c     = (phase_q == PH_COARSE) && gt_c;
	assign at_med    = (phase_q == PH_MEDIUM) || ((phase_q == PH_COARSE) && !gt_c);
	assign run_m     = at_med && gt_m;
	assign at_fine   = (phase_q == PH_FINE) || (at_med && !gt_m);
	assign run_f     = at_fine && gt_s;
	assign med_duty  = (phase_q == PH_MEDIUM) ? duty_q : DUTY_NEXT_START;
	assign fine_duty = (phase_q == PH_FINE) ? duty_q : DUTY_NEXT_START;
	assign bump_c    = duty_bump(duty_q);
	assign bump_m    = duty_bump(med_duty);
	assign bump_f    = duty_bump(fine_duty);

	always_comb begin
		phase_d = phase_q;
		dir_d   = dir_q;
		duty_d  = duty_q;
		tt_d    = tt_q;
		res     = '{dir: DIR_STOP, cmp: '0, busy: 1'b0, done: 1'b0};
		if (opcode == OP_START) begin
			tt_d = POS_W'(prod);
			if (below || above) begin
				dir_d    = below ? DIR_BACK : DIR_FWD;
				phase_d  = PH_COARSE;
				duty_d   = DUTY_COARSE_START;
				res.dir  = dir_d;
				res.busy = 1'b1;
			end else begin
				dir_d    = DIR_STOP;
				phase_d  = PH_IDLE;
				res.done = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			res.dir  = dir_q;
			res.busy = 1'b1;
			if (run_c) begin
				duty_d  = bump_c;
				res.cmp = bump_c - COMPARE_OFFSET;
			end else if (run_m) begin
				phase_d = PH_MEDIUM;
				duty_d  = bump_m;
				res.cmp = bump_m - COMPARE_OFFSET;
			end else if (run_f) begin
				phase_d = PH_FINE;
				duty_d  = bump_f;
				res.cmp = fine_duty - COMPARE_OFFSET;
			end else begin
				phase_d  = PH_IDLE;
				dir_d    = DIR_STOP;
				res.dir  = DIR_STOP;
				res.busy = 1'b0;
				res.done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dir_q   <= DIR_STOP;
			duty_q  <= '0;
			tt_q    <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			dir_q   <= dir_d;
			duty_q  <= duty_d;
			tt_q    <= tt_d;
		end
	end

endmodule

// File: hdl/zoned_steering_position_drive_core.sv
// ----------------------------------------------------------------------------
// zoned_steering_position_drive_core - zoned steering position drive
// Throughput: one item per cycle; the input register and the result register
//   together form a two-deep pipe, so the input stalls only while a result waits.
// Reset: arst_n clears pipe valids and move state, and reloads config defaults.
// ----------------------------------------------------------------------------
module zoned_steering_position_drive_core
	import zsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic [ANGLE_W-1:0] target_angle,
	input  logic [FIELD_W-1:0] position,

	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         motor_dir,
	output logic [DUTY_W-1:0]  pwm_compare,
	output logic               busy_res,
	output logic               done_res,

	// config write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [FIELD_W-1:0] cfg_data
);

	// Stage 1: registered input item.
	logic               valid_s1;
	op_t                opcode_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic [FIELD_W-1:0] position_s1;

	// Stage 2: registered result.
	logic res_valid_s2;
	res_t res_s2;

	logic advance;   // stage 1 may move into the result register
	logic step_en;   // a real item is processed this cycle
	cfg_t cfg;
	res_t res;

	// Result register frees up when empty or when its transfer happens now.
	assign advance    = !res_valid_s2 || !result_stall;
	assign step_en    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Config writes are always taken; the user must issue them only while idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	zsd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move state is updated in the same cycle the result is captured, so the
	// next item in stage 1 always sees the state left by the one before it.
	zsd_drive u_drive (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.opcode       (opcode_s1),
		.target_angle (angle_s1),
		.position     (position_s1),
		.cfg          (cfg),
		.res          (res)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Stage 1 payload, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			opcode_s1   <= op_t'(opcode);
			angle_s1    <= target_angle;
			position_s1 <= position;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload; holds while the consumer stalls
	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res;
		end
	end

	assign result_valid = res_valid_s2;
	assign motor_dir    = res_s2.dir;
	assign pwm_compare  = res_s2.cmp;
	assign busy_res     = res_s2.busy;
	assign done_res     = res_s2.done;

endmodule

// File: hdl/zsd_checker.sv
// ----------------------------------------------------------------------------
// zsd_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "zoned_steering_position_drive_core_macros.svh"

module zsd_checker
	import zsd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input logic [1:0]        motor_dir,
	input logic [DUTY_W-1:0] pwm_compare,
	input logic              busy_res,
	input logic              done_res
);

	// stalled result keeps its payload
	`ZSPD_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(motor_dir) && $stable(pwm_compare) && $stable(done_res), "stalled result changed")

	// busy exactly when a direction is driven
	`ZSPD_ASSERT(a_busy_dir, result_valid |-> (busy_res == (motor_dir == DIR_FWD || motor_dir == DIR_BACK)), "busy and direction disagree")

	// completion always stops the motor
	`ZSPD_ASSERT(a_done_stop, result_valid && done_res |-> !busy_res && motor_dir == DIR_STOP && pwm_compare == '0, "done without stop")

	// compare stays in the duty range
	`ZSPD_ASSERT(a_cmp_range, result_valid |-> pwm_compare <= COMPARE_MAX, "compare out of range")

endmodule

bind zoned_steering_position_drive_core zsd_checker u_zsd_checker (.*);

// File: dv/zoned_steering_position_drive_core_tb.sv
// ----------------------------------------------------------------------------
// zoned_steering_position_drive_core_tb - self-checking bench for the drive core
// Sends start and tick items, checks every result against an in-bench model of
// the zoned move (coarse/medium/fine phases, duty wrap, stop band, overshoot).
// Config is rewritten between phases, only with the pipe drained.
// ----------------------------------------------------------------------------
module zoned_steering_position_drive_core_tb
	import zsd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;        // cycles without any transfer
	localparam int HOLD_CYCLES = 60;          // long receiver hold-off
	localparam int DRAIN_PAUSE = 4;           // extra margin after the pipe drains
	localparam int WRAP_TARGET = 4095 * 1023; // far target for the duty wrap run

	// DUT signals; the driven inputs are all known from time zero
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic               opcode       = 1'b0;
	logic [ANGLE_W-1:0] target_angle = '0;
	logic [FIELD_W-1:0] position     = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         motor_dir;
	logic [DUTY_W-1:0]  pwm_compare;
	logic               busy_res;
	logic               done_res;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index    = '0;
	logic [FIELD_W-1:0] cfg_data     = '0;

	// model copy of the config registers
	logic [TPD_W-1:0]   pred_tpd    = TPD_RESET;
	logic [FIELD_W-1:0] pred_coarse = COARSE_RESET;
	logic [FIELD_W-1:0] pred_medium = MEDIUM_RESET;
	logic [FIELD_W-1:0] pred_stop   = STOP_RESET;

	// model copy of the move state
	phase_t             pred_phase  = PH_IDLE;
	dir_t               pred_dir    = DIR_STOP;
	logic [DUTY_W-1:0]  pred_duty   = '0;
	logic [FIELD_W-1:0] pred_target = '0;

	res_t pending_drive[$];   // expected results, oldest first
	res_t check_want;
	int   mismatches    = 0;
	int   items_sent    = 0;
	int   item_idle_pct = 38;
	int   stall_pct     = 38;
	int   hold_reqs     = 0;  // bumped by a test to ask for a hold-off
	int   hold_seen     = 0;
	int   hold_left     = 0;
	int   quiet_cycles  = 0;

	zoned_steering_position_drive_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.target_angle (target_angle),
		.position     (position),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.motor_dir    (motor_dir),
		.pwm_compare  (pwm_compare),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Drive model
	// ------------------------------------------------------------------

	// duty steps by one and wraps from 620 back to 100
	function automatic logic [DUTY_W-1:0] duty_step(logic [DUTY_W-1:0] d);
		d = d + 1'b1;
		if (d >= DUTY_WRAP_AT)
			d = DUTY_WRAP_TO;
		return d;
	endfunction

	// One item in, one result out; updates the model state.
	function automatic res_t predict_drive(op_t op, logic [ANGLE_W-1:0] ang,
			logic [FIELD_W-1:0] pos);
		res_t            r;
		longint unsigned eff;
		longint unsigned cur;
		longint          distance;
		r.dir  = DIR_STOP;
		r.cmp  = '0;
		r.busy = 1'b0;
		r.done = 1'b0;
		eff = (pred_tpd == '0) ? 1 : longint'(pred_tpd);  // zero scale acts as one

		if (op == OP_START) begin
			cur = longint'(pos) / eff;
			pred_target = FIELD_W'(longint'(ang) * eff);
			if (cur != longint'(ang)) begin
				// below the target angle drives backward, above drives forward
				if (cur < longint'(ang))
					pred_dir = DIR_BACK;
				else
					pred_dir = DIR_FWD;
				pred_phase = PH_COARSE;
				pred_duty  = DUTY_COARSE_START;
				r.dir  = pred_dir;
				r.busy = 1'b1;
			end else begin
				// already in the target degree: done at once
				pred_dir   = DIR_STOP;
				pred_phase = PH_IDLE;
				r.done     = 1'b1;
			end
			return r;
		end

		if (pred_phase == PH_IDLE)
			return r;

		// signed distance along the travel direction; overshoot goes negative
		if (pred_dir == DIR_BACK)
			distance = longint'(pred_target) - longint'(pos);
		else
			distance = longint'(pos) - longint'(pred_target);

		// phases only move forward, and one sample may fall through several
		if (pred_phase == PH_COARSE) begin
			if (distance > longint'(pred_coarse)) begin
				pred_duty = duty_step(pred_duty);
				r.dir  = pred_dir;
				r.cmp  = pred_duty - COMPARE_OFFSET;
				r.busy = 1'b1;
				return r;
			end
			pred_phase = PH_MEDIUM;
			pred_duty  = DUTY_NEXT_START;
		end
		if (pred_phase == PH_MEDIUM) begin
			if (distance > longint'(pred_medium)) begin
				pred_duty = duty_step(pred_duty);
				r.dir  = pred_dir;
				r.cmp  = pred_duty - COMPARE_OFFSET;
				r.busy = 1'b1;
				return r;
			end
			pred_phase = PH_FINE;
			pred_duty  = DUTY_NEXT_START;
		end
		if (distance > longint'(pred_stop)) begin
			// fine phase shows the duty before stepping it
			r.dir  = pred_dir;
			r.cmp  = pred_duty - COMPARE_OFFSET;
			r.busy = 1'b1;
			pred_duty = duty_step(pred_duty);
			return r;
		end
		pred_phase = PH_IDLE;
		pred_dir   = DIR_STOP;
		r.done     = 1'b1;
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_pos(longint p);
		if (p < 0)
			return '0;
		if (p > longint'({FIELD_W{1'b1}}))
			return '1;
		return FIELD_W'(p);
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// One item transfer. Valid is left high on return so a following item
	// goes out back to back; whoever stops sending lowers it.
	task automatic send_item(op_t op, logic [ANGLE_W-1:0] ang, logic [FIELD_W-1:0] pos);
		while ($urandom_range(0, 99) < item_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		opcode       <= op;
		target_angle <= ang;
		position     <= pos;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_drive.push_back(predict_drive(op, ang, pos));
		items_sent++;
	endtask

	// Rewrites all four registers once the pipe has drained.
	task automatic write_settings(logic [TPD_W-1:0] tpd, logic [FIELD_W-1:0] coarse,
			logic [FIELD_W-1:0] med_band, logic [FIELD_W-1:0] stop);
		cfg_idx_t           regs[4];
		logic [FIELD_W-1:0] vals[4];
		regs = '{CFG_TPD, CFG_COARSE, CFG_MEDIUM, CFG_STOP};
		vals = '{FIELD_W'(tpd), coarse, med_band, stop};
		item_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid   <= 1'b0;
		pred_tpd    = tpd;
		pred_coarse = coarse;
		pred_medium = med_band;
		pred_stop   = stop;
	endtask

	// Mostly well-formed moves: a start, then ticks closing in on the target,
	// sometimes overshooting, sometimes cut short by a new start. About one
	// pick in eight sends a single stray item with any opcode and payload.
	task automatic run_moves(int count);
		int              stop_at;
		int              steps;
		int unsigned     span;
		longint unsigned eff;
		longint          tgt;
		longint          distance;
		logic [ANGLE_W-1:0] ang;
		logic [FIELD_W-1:0] pos;
		bit              above;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0) begin
				send_item(op_t'(1'($urandom_range(0, 1))), ANGLE_W'($urandom),
					FIELD_W'($urandom));
			end else begin
				ang      = ANGLE_W'($urandom);
				eff      = (pred_tpd == '0) ? 1 : longint'(pred_tpd);
				tgt      = longint'(ang) * longint'(eff);
				span     = pred_coarse + pred_coarse / 2 + 4000;
				distance = longint'($urandom_range(0, span));
				above    = 1'($urandom_range(0, 1));
				send_item(OP_START, ang,
					clamp_pos(above ? tgt + distance : tgt - distance));
				steps = 0;
				while (pred_phase != PH_IDLE && steps < 40 && $urandom_range(0, 29) != 0) begin
					if (distance > 0)
						distance = distance
							- longint'($urandom_range(0, 32'(distance / 5) + 60));
					else
						distance = distance - longint'($urandom_range(0, 60));
					if ($urandom_range(0, 19) == 0)
						pos = FIELD_W'($urandom);   // encoder glitch
					else
						pos = clamp_pos(above ? tgt + distance : tgt - distance);
					send_item(OP_TICK, ANGLE_W'($urandom), pos);
					steps++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset config: idle tick, start on target, full backward move through
	// every phase, forward move from the top of the encoder range that stops
	// in one tick, overshoot stop, and a start dropped by a new start.
	task automatic test_directed_moves();
		send_item(OP_TICK, '0, '0);
		send_item(OP_START, ANGLE_W'(10), FIELD_W'(10 * 203 + 5));
		// backward: target 20300
		send_item(OP_START, ANGLE_W'(100), '0);
		send_item(OP_TICK, '0, FIELD_W'(0));       // coarse
		send_item(OP_TICK, '0, FIELD_W'(16000));   // coarse
		send_item(OP_TICK, '0, FIELD_W'(17500));   // into medium
		send_item(OP_TICK, '0, FIELD_W'(18500));   // into fine
		send_item(OP_TICK, '0, FIELD_W'(18600));   // fine
		send_item(OP_TICK, '0, FIELD_W'(20100));   // exactly on stop band
		send_item(OP_TICK, '1, '1);                // idle again
		// forward from full scale to target 0, then all phases in one tick
		send_item(OP_START, '0, '1);
		send_item(OP_TICK, '0, '1);
		send_item(OP_TICK, '0, FIELD_W'(150));
		// largest angle, then overshoot past the target
		send_item(OP_START, '1, '0);
		send_item(OP_TICK, '0, FIELD_W'(4095 * 203 + 1000));
		// new start while a move is running
		send_item(OP_START, ANGLE_W'(50), '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_START, ANGLE_W'(20), '1);
		send_item(OP_TICK, '0, FIELD_W'(20 * 203 + 3000));
		send_item(OP_TICK, '0, FIELD_W'(20 * 203 + 100));
	endtask

	// Register extremes: zero scale (taken as one) with zero bands, then
	// full scale with full bands where any move stops on the first tick.
	task automatic test_config_extremes();
		write_settings('0, '0, '0, '0);
		send_item(OP_START, '1, FIELD_W'(4095));
		send_item(OP_START, '1, '0);
		send_item(OP_TICK, '0, FIELD_W'(4094));
		send_item(OP_TICK, '0, FIELD_W'(4095));
		write_settings('1, '1, '1, '1);
		send_item(OP_START, '1, '0);
		send_item(OP_TICK, '0, '0);
	endtask

	// Long coarse run and long fine run, each long enough to wrap the duty.
	task automatic test_duty_wrap();
		write_settings(TPD_W'(1023), FIELD_W'(1000000), FIELD_W'(10000), FIELD_W'(100));
		send_item(OP_START, '1, '0);
		repeat (325)
			send_item(OP_TICK, ANGLE_W'($urandom),
				FIELD_W'($urandom_range(0, WRAP_TARGET - 1000001)));
		repeat (425)
			send_item(OP_TICK, ANGLE_W'($urandom),
				FIELD_W'(WRAP_TARGET - $urandom_range(101, 10000)));
		send_item(OP_TICK, ANGLE_W'($urandom),
			FIELD_W'(WRAP_TARGET + $urandom_range(0, 5000)));
	endtask

	// Several random settings, ordered bands mostly, unordered once.
	task automatic test_random_moves();
		logic [TPD_W-1:0]   tpd;
		logic [FIELD_W-1:0] stop;
		logic [FIELD_W-1:0] med_band;
		logic [FIELD_W-1:0] coarse;
		for (int n = 0; n < 4; n++) begin
			if ($urandom_range(0, 9) == 0)
				tpd = '0;
			else
				tpd = TPD_W'($urandom_range(1, 1023));
			if (n == 3) begin
				stop     = FIELD_W'($urandom);
				med_band = FIELD_W'($urandom);
				coarse   = FIELD_W'($urandom);
			end else begin
				stop     = FIELD_W'($urandom_range(0, 3000));
				med_band = stop + FIELD_W'($urandom_range(0, 30000));
				coarse   = med_band + FIELD_W'($urandom_range(0, 200000));
			end
			write_settings(tpd, coarse, med_band, stop);
			run_moves(60);
		end
	endtask

	// No idling at all, and the receiver holds off long enough that the
	// core fills and stalls its input while items keep coming.
	task automatic test_backpressure();
		item_idle_pct = 0;
		stall_pct     = 0;
		hold_reqs++;
		run_moves(60);
		item_idle_pct = 38;
		stall_pct     = 38;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_moves();
		test_config_extremes();
		test_duty_wrap();
		test_random_moves();
		test_backpressure();
		item_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		if (mismatches == 0)
			$display("zoned_steering_position_drive_core_tb passed");
		else
			$display("zoned_steering_position_drive_core_tb failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver, checker, watchdog
	// ------------------------------------------------------------------

	// random stall, or a counted hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (hold_reqs != hold_seen) begin
			hold_seen    <= hold_reqs;
			hold_left    <= HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// every result transfer is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_drive.size() == 0) begin
				$display("%0t: result with nothing expected: dir %0d cmp %0d busy %0d done %0d",
					$time, motor_dir, pwm_compare, busy_res, done_res);
				mismatches++;
			end else begin
				check_want = pending_drive.pop_front();
				if (motor_dir !== check_want.dir) begin
					$display("%0t: motor_dir expected %0d actual %0d",
						$time, check_want.dir, motor_dir);
					mismatches++;
				end
				if (pwm_compare !== check_want.cmp) begin
					$display("%0t: pwm_compare expected %0d actual %0d",
						$time, check_want.cmp, pwm_compare);
					mismatches++;
				end
				if (busy_res !== check_want.busy) begin
					$display("%0t: busy_res expected %0d actual %0d",
						$time, check_want.busy, busy_res);
					mismatches++;
				end
				if (done_res !== check_want.done) begin
					$display("%0t: done_res expected %0d actual %0d",
						$time, check_want.done, done_res);
					mismatches++;
				end
			end
		end
	end

	// ends a hung run: too many cycles with no transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("zoned_steering_position_drive_core_tb failed");
			$finish;
		end
	end

endmodule
